### hw/rtl/i2cea_pkg.sv
// Package for the EEPROM access I2C master: phase encoding, result item
// layout and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package i2cea_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned S_TDATA_W = 24;
	localparam int unsigned M_TDATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEVICE_ADDRESS = 1'd0,
		CFG_ACK_WAIT_LIMIT = 1'd1
	} cfg_idx_t;

	localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
	localparam logic [7:0] ACK_WAIT_LIMIT_RST = 8'd25;

	// Byte selector values inside one transfer.
	localparam logic [1:0] SEL_DEVICE  = 2'd0;
	localparam logic [1:0] SEL_ADDRESS = 2'd1;
	localparam logic [1:0] SEL_THIRD   = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_ST_SDAHI  = 5'd1,
		PH_ST_SCLHI  = 5'd2,
		PH_ST_SDALO  = 5'd3,
		PH_WB_SCLLO  = 5'd4,
		PH_WB_DATA   = 5'd5,
		PH_WB_SCLHI  = 5'd6,
		PH_WB_ENDLO  = 5'd7,
		PH_WB_REL    = 5'd8,
		PH_ACK_SCLHI = 5'd9,
		PH_ACK_WAIT  = 5'd10,
		PH_RB_SCLLO  = 5'd11,
		PH_RB_REL    = 5'd12,
		PH_RB_SCLHI  = 5'd13,
		PH_RB_SAMPLE = 5'd14,
		PH_SP_SDALO  = 5'd15,
		PH_SP_SCLHI  = 5'd16,
		PH_SP_SDAHI  = 5'd17
	} phase_t;

	typedef struct packed {
		logic       ack_missing;
		logic [7:0] read_value;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       scl_out;
	} res_t;

endpackage

### hw/rtl/i2cea_seq.sv
// Bus sequencer of the EEPROM access I2C master: one phase step per accepted
// tick item, with the result of that tick. Depends on i2cea_pkg.
`timescale 1ns / 1ps

module i2cea_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              go,
	input  logic              func,
	input  logic [7:0]        mem_address,
	input  logic [7:0]        write_value,
	input  logic              sda_in,
	input  logic [6:0]        device_address,
	input  logic [7:0]        ack_wait_limit,
	output i2cea_pkg::res_t   res
);
	import i2cea_pkg::*;

	phase_t     phase_q, phase_d;
	logic [1:0] byte_sel_q, byte_sel_d;
	logic [3:0] bit_count_q, bit_count_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] wait_q, wait_d;
	logic       is_read_q, is_read_d;
	logic [7:0] addr_q, addr_d;
	logic [7:0] value_q, value_d;
	logic [7:0] rx_byte_q, rx_byte_d;
	logic       nack_q, nack_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       done_d;
	logic [3:0] bit_inc;
	logic [7:0] rx_shift;

	assign bit_inc  = bit_count_q + 4'd1;
	assign rx_shift = {shift_q[6:0], sda_in};

	// Next state.
	always_comb begin
		phase_d     = phase_q;
		byte_sel_d  = byte_sel_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		wait_d      = wait_q;
		is_read_d   = is_read_q;
		addr_d      = addr_q;
		value_d     = value_q;
		rx_byte_d   = rx_byte_q;
		nack_d      = nack_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		done_d      = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (go) begin
					is_read_d   = func;
					addr_d      = mem_address;
					value_d     = write_value;
					nack_d      = 1'b0;
					byte_sel_d  = SEL_DEVICE;
					bit_count_d = 4'd0;
					sda_d       = 1'b1;
					phase_d     = PH_ST_SCLHI;
				end
			end
			PH_ST_SDAHI: begin
				sda_d   = 1'b1;
				phase_d = PH_ST_SCLHI;
			end
			PH_ST_SCLHI: begin
				scl_d   = 1'b1;
				phase_d = PH_ST_SDALO;
			end
			PH_ST_SDALO: begin
				sda_d       = 1'b0;
				shift_d     = {device_address, byte_sel_q == SEL_THIRD};
				bit_count_d = 4'd0;
				phase_d     = PH_WB_SCLLO;
			end
			PH_WB_SCLLO: begin
				scl_d   = 1'b0;
				phase_d = PH_WB_DATA;
			end
			PH_WB_DATA: begin
				sda_d   = shift_q[7];
				shift_d = {shift_q[6:0], 1'b0};
				phase_d = PH_WB_SCLHI;
			end
			PH_WB_SCLHI: begin
				scl_d       = 1'b1;
				bit_count_d = bit_inc;
				phase_d     = (bit_inc >= BITS_PER_BYTE) ? PH_WB_ENDLO : PH_WB_SCLLO;
			end
			PH_WB_ENDLO: begin
				scl_d   = 1'b0;
				phase_d = PH_WB_REL;
			end
			PH_WB_REL: begin
				sda_d   = 1'b1;
				phase_d = PH_ACK_SCLHI;
			end
			PH_ACK_SCLHI: begin
				scl_d   = 1'b1;
				wait_d  = 8'd0;
				phase_d = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				if (sda_in && (wait_q < ack_wait_limit)) begin
					wait_d = wait_q + 8'd1;
				end else begin
					if (sda_in) begin
						nack_d = 1'b1;
					end
					scl_d = 1'b0;
					// Choose the next byte; a read turns around with a repeated start.
					priority if (byte_sel_q == SEL_DEVICE) begin
						byte_sel_d  = SEL_ADDRESS;
						shift_d     = addr_q;
						bit_count_d = 4'd0;
						phase_d     = PH_WB_SCLLO;
					end else if (byte_sel_q == SEL_ADDRESS) begin
						byte_sel_d = SEL_THIRD;
						if (is_read_q) begin
							phase_d = PH_ST_SDAHI;
						end else begin
							shift_d     = value_q;
							bit_count_d = 4'd0;
							phase_d     = PH_WB_SCLLO;
						end
					end else begin
						phase_d = is_read_q ? PH_RB_SCLLO : PH_SP_SDALO;
					end
				end
			end
			PH_RB_SCLLO: begin
				scl_d   = 1'b0;
				phase_d = PH_RB_REL;
			end
			PH_RB_REL: begin
				sda_d       = 1'b1;
				bit_count_d = 4'd0;
				shift_d     = 8'd0;
				phase_d     = PH_RB_SCLHI;
			end
			PH_RB_SCLHI: begin
				scl_d   = 1'b1;
				phase_d = PH_RB_SAMPLE;
			end
			PH_RB_SAMPLE: begin
				shift_d     = rx_shift;
				scl_d       = 1'b0;
				bit_count_d = bit_inc;
				if (bit_inc >= BITS_PER_BYTE) begin
					rx_byte_d = rx_shift;
					phase_d   = PH_SP_SDALO;
				end else begin
					phase_d = PH_RB_SCLHI;
				end
			end
			PH_SP_SDALO: begin
				sda_d   = 1'b0;
				phase_d = PH_SP_SCLHI;
			end
			PH_SP_SCLHI: begin
				scl_d   = 1'b1;
				phase_d = PH_SP_SDAHI;
			end
			PH_SP_SDAHI: begin
				sda_d   = 1'b1;
				done_d  = 1'b1;
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Result of this tick, taken from the updated state.
	always_comb begin
		res.scl_out     = scl_d;
		res.sda_out     = sda_d;
		res.busy_res    = (phase_d != PH_IDLE);
		res.done_res    = done_d;
		res.read_value  = rx_byte_d;
		res.ack_missing = nack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_sel_q  <= SEL_DEVICE;
			bit_count_q <= 4'd0;
			shift_q     <= 8'd0;
			wait_q      <= 8'd0;
			is_read_q   <= 1'b0;
			addr_q      <= 8'd0;
			value_q     <= 8'd0;
			rx_byte_q   <= 8'd0;
			nack_q      <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
		end else if (step) begin
			phase_q     <= phase_d;
			byte_sel_q  <= byte_sel_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
			wait_q      <= wait_d;
			is_read_q   <= is_read_d;
			addr_q      <= addr_d;
			value_q     <= value_d;
			rx_byte_q   <= rx_byte_d;
			nack_q      <= nack_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
		end
	end

endmodule

### hw/rtl/i2cea_outreg.sv
// Result register of the EEPROM access I2C master: holds one result item
// until the downstream side takes it. Depends on i2cea_pkg.
`timescale 1ns / 1ps

module i2cea_outreg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  i2cea_pkg::res_t                    res,
	output logic                               free,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [i2cea_pkg::M_TDATA_W-1:0]    m_tdata
);
	import i2cea_pkg::*;

	logic valid_q;
	res_t res_q;

	// A new item may enter while the held one leaves in the same cycle.
	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_TDATA_W - $bits(res_t)){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

### hw/rtl/i2c_eeprom_access_master.sv
// Tick-driven I2C master for byte write and random read of a serial EEPROM.
// Each accepted tick item gives its result item from the result register in the
// cycle after it is accepted; one item per cycle is sustained while the output is taken.
// Reset (arst_n low) returns the sequencer to idle with both lines released
// and the configuration registers to address 80 and wait limit 25.
`timescale 1ns / 1ps

module i2c_eeprom_access_master (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0: go, mem_address[7:0], write_value[7:0], sda_in.
	input  logic [i2cea_pkg::S_TDATA_W-1:0]    s_tdata,
	// Fields from bit 0: func.
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// Fields from bit 0: scl_out, sda_out, busy_res, done_res,
	// read_value[7:0], ack_missing.
	output logic [i2cea_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [i2cea_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                         cfg_data
);
	import i2cea_pkg::*;

	logic [6:0] device_address_q;
	logic [7:0] ack_wait_limit_q;
	logic       free;
	logic       step;
	res_t       res;

	assign cfg_ready = 1'b1;
	assign s_tready  = free;
	assign step      = s_tvalid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEVICE_ADDRESS_RST;
			ack_wait_limit_q <= ACK_WAIT_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[6:0];
				CFG_ACK_WAIT_LIMIT: ack_wait_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	i2cea_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.go             (s_tdata[0]),
		.func           (s_tuser),
		.mem_address    (s_tdata[8:1]),
		.write_value    (s_tdata[16:9]),
		.sda_in         (s_tdata[17]),
		.device_address (device_address_q),
		.ack_wait_limit (ack_wait_limit_q),
		.res            (res)
	);

	i2cea_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
